[rtl/hcp_pkg.sv]
// Package for the HTTP chunk header parser: field widths, byte codes,
// status encodings, result layout and the hex digit decoder.
// No dependencies.
package hcp_pkg;

    localparam int CHUNK_LEN_W = 60;
    localparam int EXPECTED_W  = 61;
    localparam int EXT_LEN_W   = 16;
    localparam int CHUNK_NUM_W = 32;
    localparam int SIG_W       = 5;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 176;

    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_EOL  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        SIZE_OK        = 2'd0,
        SIZE_MISSING   = 2'd1,
        SIZE_MALFORMED = 2'd2
    } size_status_t;

    typedef enum logic [1:0] {
        EXT_NONE    = 2'd0,
        EXT_EMPTY   = 2'd1,
        EXT_PRESENT = 2'd2
    } ext_status_t;

    typedef enum logic [1:0] {
        NEXT_BODY    = 2'd0,
        NEXT_TRAILER = 2'd1,
        NEXT_CLOSED  = 2'd2
    } section_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic [CHUNK_NUM_W-1:0] chunk_number;
        logic [EXPECTED_W-1:0]  bytes_expected;
        section_t               next_section;
        logic                   truncated;
        logic [EXT_LEN_W-1:0]   extension_length;
        ext_status_t            extension_status;
        size_status_t           size_status;
        logic [CHUNK_LEN_W-1:0] chunk_length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t   h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            d     = b - CHAR_ZERO;
            h.ok  = 1'b1;
        end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
            d     = b - CHAR_UPPER_A + HEX_TEN;
            h.ok  = 1'b1;
        end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
            d     = b - CHAR_LOWER_A + HEX_TEN;
            h.ok  = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage

[rtl/http_chunk_header_parser.sv]
// Chunk header line parser: input register, per-line state, result register.
// Depends on hcp_pkg.
//
// Takes one transfer per clock, line bytes and end-of-line alike, and keeps
// taking bytes while a result waits on the master side. A byte updates the
// running size and counters in the cycle after it is accepted; an end-of-line
// transfer passes from the input register into the result register, shown on
// m_axis, once that register is free. Only end-of-line transfers produce
// results, and only they wait for room in the result register; while one
// waits, s_axis_tready stays low until m_axis takes the pending result.
module http_chunk_header_parser #(
    parameter int LINE_MAX_BYTES         = 65535,
    parameter int MAX_SIGNIFICANT_DIGITS = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] byte_value, [8] connection_closed, [15:9] zero
    input  logic [hcp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] action
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [59:0] chunk_length, [61:60] size_status, [63:62] extension_status,
    // [79:64] extension_length, [80] truncated, [82:81] next_section,
    // [143:83] bytes_expected, [175:144] chunk_number
    output logic [hcp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(LINE_MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_MAX_BYTES);
    localparam logic [hcp_pkg::SIG_W-1:0] SIG_MAX =
        hcp_pkg::SIG_W'(MAX_SIGNIFICANT_DIGITS);

    logic                 in_valid_reg;
    hcp_pkg::action_t     in_action_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_closed_reg;

    logic [hcp_pkg::CHUNK_LEN_W-1:0] acc_reg, acc_next;
    logic [hcp_pkg::SIG_W-1:0]       sig_reg, sig_next;
    logic [CNT_W-1:0]                size_cnt_reg, size_cnt_next;
    logic [CNT_W-1:0]                ext_cnt_reg, ext_cnt_next;
    logic                            semi_reg, semi_next;
    logic                            bad_reg, bad_next;
    logic [hcp_pkg::CHUNK_NUM_W-1:0] chunk_cnt_reg, chunk_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    hcp_pkg::result_t     result_reg, result_next;

    logic                 advance;
    logic                 is_eol;
    logic                 out_free;
    logic [hcp_pkg::SIG_W-1:0] sig_inc;
    hcp_pkg::hex_t        hex;

    assign is_eol   = (in_action_reg == hcp_pkg::ACT_EOL);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance  = in_valid_reg && (!is_eol || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_action_reg <= hcp_pkg::action_t'(s_axis_tuser);
            in_byte_reg   <= s_axis_tdata[7:0];
            in_closed_reg <= s_axis_tdata[8];
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        sig_next       = sig_reg;
        size_cnt_next  = size_cnt_reg;
        ext_cnt_next   = ext_cnt_reg;
        semi_next      = semi_reg;
        bad_next       = bad_reg;
        chunk_cnt_next = chunk_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        result_next    = result_reg;
        hex            = hcp_pkg::hex_digit(in_byte_reg);
        sig_inc        = sig_reg;
        if (sig_reg != '0 || in_byte_reg != hcp_pkg::CHAR_ZERO) begin
            sig_inc = sig_reg + 1'b1;
        end

        if (advance && !is_eol) begin
            if (semi_reg) begin
                if (ext_cnt_reg < CNT_MAX) begin
                    ext_cnt_next = ext_cnt_reg + 1'b1;
                end
            end else if (in_byte_reg == hcp_pkg::CHAR_SEMI) begin
                semi_next = 1'b1;
            end else begin
                if (size_cnt_reg < CNT_MAX) begin
                    size_cnt_next = size_cnt_reg + 1'b1;
                end
                if (!bad_reg) begin
                    sig_next = sig_inc;
                    if (sig_inc > SIG_MAX || !hex.ok) begin
                        bad_next = 1'b1;
                    end else begin
                        acc_next = {acc_reg[hcp_pkg::CHUNK_LEN_W-5:0], hex.val};
                    end
                end
            end
        end

        if (advance && is_eol) begin
            chunk_cnt_next = chunk_cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            result_next    = '0;
            result_next.chunk_number = chunk_cnt_reg + 1'b1;
            result_next.truncated    = in_closed_reg;
            if (size_cnt_reg == '0) begin
                result_next.size_status = hcp_pkg::SIZE_MISSING;
            end else if (bad_reg) begin
                result_next.size_status = hcp_pkg::SIZE_MALFORMED;
            end else begin
                result_next.size_status  = hcp_pkg::SIZE_OK;
                result_next.chunk_length = acc_reg;
            end
            if (!semi_reg) begin
                result_next.extension_status = hcp_pkg::EXT_NONE;
            end else begin
                result_next.extension_length = hcp_pkg::EXT_LEN_W'(ext_cnt_reg);
                result_next.extension_status = (ext_cnt_reg == '0) ?
                    hcp_pkg::EXT_EMPTY : hcp_pkg::EXT_PRESENT;
            end
            if (in_closed_reg) begin
                result_next.next_section = hcp_pkg::NEXT_CLOSED;
            end else if (size_cnt_reg != '0 && !bad_reg && acc_reg != '0) begin
                result_next.next_section   = hcp_pkg::NEXT_BODY;
                result_next.bytes_expected =
                    {1'b0, acc_reg} + hcp_pkg::EXPECTED_W'(2);
            end else begin
                result_next.next_section = hcp_pkg::NEXT_TRAILER;
            end
            acc_next      = '0;
            sig_next      = '0;
            size_cnt_next = '0;
            ext_cnt_next  = '0;
            semi_next     = 1'b0;
            bad_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            sig_reg       <= '0;
            size_cnt_reg  <= '0;
            ext_cnt_reg   <= '0;
            semi_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            chunk_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            sig_reg       <= sig_next;
            size_cnt_reg  <= size_cnt_next;
            ext_cnt_reg   <= ext_cnt_next;
            semi_reg      <= semi_next;
            bad_reg       <= bad_next;
            chunk_cnt_reg <= chunk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

[dv/http_chunk_header_parser_tb.sv]
// Self-checking testbench for http_chunk_header_parser: queued line bytes and
// end-of-line transfers, an in-bench header parser predicting each result.
// Depends on hcp_pkg and the parser RTL.
module http_chunk_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT  = 65535;
    localparam int DIGIT_LIMIT = 15;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        hcp_pkg::action_t act;
        logic [7:0]       value;
        logic             closed;
    } line_item_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hcp_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hcp_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    http_chunk_header_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    line_item_t         line_items[$];
    hcp_pkg::result_t   header_results_due[$];

    // running parse state of the current line
    logic [hcp_pkg::CHUNK_LEN_W-1:0] size_value;
    int                              digit_count;
    int                              size_bytes;
    bit                              semi_seen;
    bit                              size_failed;
    int                              ext_bytes;
    logic [hcp_pkg::CHUNK_NUM_W-1:0] lines_seen;

    bit  failed;
    bit  s_taken;
    int  n_accepted;
    int  cycle_count;
    int  phase_mark1;
    int  phase_mark2;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  hold_left;
    bit  hold_done;

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'h0;
        if (c >= hcp_pkg::CHAR_ZERO && c <= hcp_pkg::CHAR_NINE) begin
            nib = 4'(c - hcp_pkg::CHAR_ZERO);
            return 1'b1;
        end
        if (c >= hcp_pkg::CHAR_UPPER_A && c <= hcp_pkg::CHAR_UPPER_F) begin
            nib = 4'(c - hcp_pkg::CHAR_UPPER_A + 8'd10);
            return 1'b1;
        end
        if (c >= hcp_pkg::CHAR_LOWER_A && c <= hcp_pkg::CHAR_LOWER_F) begin
            nib = 4'(c - hcp_pkg::CHAR_LOWER_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_line_state();
        size_value  = '0;
        digit_count = 0;
        size_bytes  = 0;
        semi_seen   = 1'b0;
        size_failed = 1'b0;
        ext_bytes   = 0;
    endtask

    task automatic parse_line_item(input line_item_t it);
        logic [3:0]       nib;
        hcp_pkg::result_t r;
        if (it.act == hcp_pkg::ACT_BYTE) begin
            if (semi_seen) begin
                if (ext_bytes < LINE_LIMIT) ext_bytes++;
            end else if (it.value == hcp_pkg::CHAR_SEMI) begin
                semi_seen = 1'b1;
            end else begin
                if (size_bytes < LINE_LIMIT) size_bytes++;
                if (!size_failed) begin
                    if (digit_count != 0 || it.value != hcp_pkg::CHAR_ZERO) digit_count++;
                    if (digit_count > DIGIT_LIMIT) size_failed = 1'b1;
                    else if (!hex_nibble(it.value, nib)) size_failed = 1'b1;
                    else size_value = {size_value[hcp_pkg::CHUNK_LEN_W-5:0], nib};
                end
            end
        end else begin
            lines_seen++;
            r = '0;
            if (size_bytes == 0) begin
                r.size_status = hcp_pkg::SIZE_MISSING;
            end else if (size_failed) begin
                r.size_status = hcp_pkg::SIZE_MALFORMED;
            end else begin
                r.size_status  = hcp_pkg::SIZE_OK;
                r.chunk_length = size_value;
            end
            if (!semi_seen) r.extension_status = hcp_pkg::EXT_NONE;
            else if (ext_bytes == 0) r.extension_status = hcp_pkg::EXT_EMPTY;
            else r.extension_status = hcp_pkg::EXT_PRESENT;
            r.extension_length = semi_seen ? hcp_pkg::EXT_LEN_W'(ext_bytes) : '0;
            r.truncated = it.closed;
            if (it.closed) begin
                r.next_section = hcp_pkg::NEXT_CLOSED;
            end else if (r.size_status == hcp_pkg::SIZE_OK && r.chunk_length != 0) begin
                r.next_section   = hcp_pkg::NEXT_BODY;
                r.bytes_expected = {1'b0, r.chunk_length} + hcp_pkg::EXPECTED_W'(2);
            end else begin
                r.next_section = hcp_pkg::NEXT_TRAILER;
            end
            r.chunk_number = lines_seen;
            header_results_due.push_back(r);
            clear_line_state();
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    task automatic check_header_result(input hcp_pkg::result_t got);
        hcp_pkg::result_t want;
        if (header_results_due.size() == 0) begin
            $error("result transfer with nothing expected: 0x%0h", got);
            failed = 1'b1;
        end else begin
            want = header_results_due.pop_front();
            check_field("chunk_length", 64'(want.chunk_length), 64'(got.chunk_length));
            check_field("size_status", 64'(want.size_status), 64'(got.size_status));
            check_field("extension_status", 64'(want.extension_status),
                        64'(got.extension_status));
            check_field("extension_length", 64'(want.extension_length),
                        64'(got.extension_length));
            check_field("truncated", 64'(want.truncated), 64'(got.truncated));
            check_field("next_section", 64'(want.next_section), 64'(got.next_section));
            check_field("bytes_expected", 64'(want.bytes_expected),
                        64'(got.bytes_expected));
            check_field("chunk_number", 64'(want.chunk_number), 64'(got.chunk_number));
        end
    endtask

    // sample side: acceptance, prediction, result check, pacing, timeout
    always @(posedge aclk) begin
        cycle_count++;
        s_taken = 1'b0;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                s_taken = 1'b1;
                n_accepted++;
                parse_line_item(line_item_t'{hcp_pkg::action_t'(s_axis_tuser),
                                             s_axis_tdata[7:0], s_axis_tdata[8]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_header_result(hcp_pkg::result_t'(m_axis_tdata));
            end
        end
        tx_idle_pct = (n_accepted < phase_mark1) ? 36 : (n_accepted < phase_mark2) ? 73 : 0;
        rx_idle_pct = (n_accepted < phase_mark1) ? 73 : (n_accepted < phase_mark2) ? 36 : 0;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender
    always @(negedge aclk) begin
        line_item_t it;
        if (aresetn && (!s_axis_tvalid || s_taken)) begin
            if (line_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = line_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, it.closed, it.value};
                s_axis_tuser  <= it.act;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the parser up
    always @(negedge aclk) begin
        if (!hold_done && phase_mark2 != 0 && n_accepted >= phase_mark2 + 100) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] value);
        line_items.push_back(line_item_t'{hcp_pkg::ACT_BYTE, value, 1'($urandom_range(1))});
    endtask

    task automatic push_eol(input bit closed);
        line_items.push_back(line_item_t'{hcp_pkg::ACT_EOL, 8'($urandom_range(255)), closed});
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return hcp_pkg::CHAR_ZERO + 8'(v);
        if ($urandom_range(1)) return hcp_pkg::CHAR_UPPER_A + 8'(v - 10);
        return hcp_pkg::CHAR_LOWER_A + 8'(v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] nib;
        do c = 8'($urandom_range(255));
        while (hex_nibble(c, nib) || c == hcp_pkg::CHAR_SEMI);
        return c;
    endfunction

    task automatic push_digits(input int n_zero, input int n_sig, input bit all_f,
                               input int bad_at);
        for (int i = 0; i < n_zero; i++) push_byte(hcp_pkg::CHAR_ZERO);
        for (int i = 0; i < n_sig; i++) begin
            if (i == bad_at) push_byte(non_hex_char());
            else if (all_f) push_byte(hex_char(15));
            else if (i == 0) push_byte(hex_char($urandom_range(1, 15)));
            else push_byte(hex_char($urandom_range(15)));
        end
    endtask

    task automatic add_random_line();
        int  kind;
        int  n_sig;
        bit  with_ext;
        kind     = $urandom_range(99);
        with_ext = 1'($urandom_range(1));
        if (kind < 55) begin
            n_sig = ($urandom_range(7) == 0) ? DIGIT_LIMIT : $urandom_range(1, 8);
            push_digits(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, n_sig,
                        $urandom_range(7) == 0, -1);
        end else if (kind < 65) begin
            push_digits($urandom_range(2), $urandom_range(DIGIT_LIMIT + 1, DIGIT_LIMIT + 3),
                        $urandom_range(3) == 0, -1);
        end else if (kind < 75) begin
            n_sig = $urandom_range(1, 6);
            push_digits($urandom_range(1), n_sig, 1'b0, $urandom_range(n_sig - 1));
        end else if (kind < 85) begin
            push_digits($urandom_range(1, 3), 0, 1'b0, -1);
        end else if (kind < 93) begin
            with_ext = ($urandom_range(9) < 7);
        end else begin
            with_ext = 1'b0;
            repeat ($urandom_range(10)) push_byte(8'($urandom_range(255)));
        end
        if (with_ext) begin
            push_byte(hcp_pkg::CHAR_SEMI);
            repeat ($urandom_range(6)) push_byte(8'($urandom_range(255)));
        end
        push_eol($urandom_range(6) == 0);
    endtask

    initial begin
        clear_line_state();
        lines_seen = '0;

        // directed: empty closed line, extension only with a later semicolon,
        // bad digit, zero size with empty extension, mixed-case body, closed body
        push_eol(1'b1);
        push_byte(hcp_pkg::CHAR_SEMI);
        push_byte(hcp_pkg::CHAR_SEMI);
        push_byte(8'hFF);
        push_eol(1'b0);
        push_byte(hcp_pkg::CHAR_ZERO);
        push_byte(8'h00);
        push_eol(1'b0);
        push_byte(hcp_pkg::CHAR_ZERO);
        push_byte(hcp_pkg::CHAR_ZERO);
        push_byte(hcp_pkg::CHAR_SEMI);
        push_eol(1'b0);
        push_byte(hcp_pkg::CHAR_UPPER_F);
        push_byte(hcp_pkg::CHAR_LOWER_A);
        push_byte(hcp_pkg::CHAR_NINE);
        push_byte(hcp_pkg::CHAR_SEMI);
        push_byte(8'h7A);
        push_eol(1'b0);
        push_byte(hcp_pkg::CHAR_ZERO + 8'd1);
        push_eol(1'b1);

        while (line_items.size() < 420) add_random_line();
        phase_mark1 = line_items.size();
        while (line_items.size() < 840) add_random_line();
        phase_mark2 = line_items.size();
        while (line_items.size() < 1250) add_random_line();

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (line_items.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (header_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (header_results_due.size() != 0) begin
            $error("%0d results never arrived", header_results_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
